// ----- rtl/vector_cosine_similarity_defines.svh -----
// assertion helpers for the cosine similarity block
`ifndef VECTOR_COSINE_SIMILARITY_DEFINES_SVH
`define VECTOR_COSINE_SIMILARITY_DEFINES_SVH

// same-cycle implication, masked while in reset
`define VCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define VCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vcs_pkg.sv -----
package vcs_pkg;

  localparam int ELEM_W   = 16;
  localparam int DOT_W    = 44;
  localparam int SQ_W     = 43;
  localparam int SIM_W    = 16;
  localparam int HALF_W   = 22;
  localparam int PROD_W   = 2 * HALF_W;
  localparam int WIDE_W   = 2 * PROD_W;
  localparam int ROOT_W   = 44;
  localparam int REM_W    = 46;
  localparam int MAG_W    = 44;
  localparam int QUO_W    = 17;
  localparam int CNT_W    = 6;

  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(4);
  localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(43);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(17);

  localparam logic [SIM_W-1:0] SIM_MAX = 16'h7fff;
  localparam logic [SIM_W-1:0] SIM_MIN = 16'h8000;
  localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

  // finished sums of one vector pair
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         sq_a;
    logic [SQ_W-1:0]         sq_b;
  } acc_t;

  typedef struct packed {
    logic full;
    logic one_left;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/vcs_front.sv -----
module vcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tlast,
  input  vcs_pkg::q_status_t  q_status,
  output logic                push,
  output vcs_pkg::acc_t       push_data
);

  logic signed [31:0] prod_ab_r;
  logic [30:0]        prod_aa_r;
  logic [30:0]        prod_bb_r;
  logic               s1_valid_r;
  logic               s1_last_r;

  logic signed [vcs_pkg::DOT_W-1:0] dot_r, dot_nxt;
  logic [vcs_pkg::SQ_W-1:0]         sqa_r, sqa_nxt;
  logic [vcs_pkg::SQ_W-1:0]         sqb_r, sqb_nxt;

  logic signed [vcs_pkg::ELEM_W-1:0] a_s, b_s;
  logic signed [31:0] mul_ab, mul_aa, mul_bb;
  logic signed [vcs_pkg::DOT_W:0] dot_sum;
  logic [vcs_pkg::SQ_W:0] sqa_sum, sqb_sum;
  logic accept;

  assign a_s = $signed(in_tdata[15:0]);
  assign b_s = $signed(in_tdata[31:16]);
  assign mul_ab = a_s * b_s;
  assign mul_aa = a_s * a_s;
  assign mul_bb = b_s * b_s;

  // hold off while a pending last item could overrun the queue
  assign in_tready = !q_status.full && !(s1_valid_r && s1_last_r && q_status.one_left);
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_last_r  <= accept && in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_ab_r <= mul_ab;
      prod_aa_r <= mul_aa[30:0];
      prod_bb_r <= mul_bb[30:0];
    end
  end

  // saturating accumulation
  always_comb begin
    dot_sum = {dot_r[vcs_pkg::DOT_W-1], dot_r} + (vcs_pkg::DOT_W+1)'(prod_ab_r);
    sqa_sum = {1'b0, sqa_r} + (vcs_pkg::SQ_W+1)'(prod_aa_r);
    sqb_sum = {1'b0, sqb_r} + (vcs_pkg::SQ_W+1)'(prod_bb_r);
    if (dot_sum[vcs_pkg::DOT_W] != dot_sum[vcs_pkg::DOT_W-1]) begin
      dot_nxt = {dot_sum[vcs_pkg::DOT_W], {(vcs_pkg::DOT_W-1){!dot_sum[vcs_pkg::DOT_W]}}};
    end else begin
      dot_nxt = dot_sum[vcs_pkg::DOT_W-1:0];
    end
    sqa_nxt = sqa_sum[vcs_pkg::SQ_W] ? '1 : sqa_sum[vcs_pkg::SQ_W-1:0];
    sqb_nxt = sqb_sum[vcs_pkg::SQ_W] ? '1 : sqb_sum[vcs_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      sqa_r <= '0;
      sqb_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        dot_r <= '0;
        sqa_r <= '0;
        sqb_r <= '0;
      end else begin
        dot_r <= dot_nxt;
        sqa_r <= sqa_nxt;
        sqb_r <= sqb_nxt;
      end
    end
  end

  assign push           = s1_valid_r && s1_last_r;
  assign push_data.dot  = dot_nxt;
  assign push_data.sq_a = sqa_nxt;
  assign push_data.sq_b = sqb_nxt;

endmodule

// ----- rtl/vcs_queue.sv -----
module vcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vcs_pkg::acc_t      push_data,
  input  logic               pop,
  output vcs_pkg::acc_t      head,
  output logic               head_valid,
  output vcs_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(DEPTH - 1);

  vcs_pkg::acc_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign head            = mem_r[rd_ptr_r];
  assign head_valid      = (count_r != '0);
  assign status.full     = (count_r == CNT_FULL);
  assign status.one_left = (count_r == CNT_ONE);

endmodule

// ----- rtl/vcs_back.sv -----
module vcs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vcs_pkg::acc_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tuser
);

  vcs_pkg::state_t state_r, state_nxt;

  logic [vcs_pkg::CNT_W-1:0]  cnt_r;
  logic [vcs_pkg::SQ_W-1:0]   sqa_r, sqb_r;
  logic [vcs_pkg::MAG_W-1:0]  mag_r;
  logic                       neg_r;
  logic                       zero_r;
  logic [vcs_pkg::PROD_W-1:0] prod_r;
  logic [1:0]                 sh_r;
  logic [vcs_pkg::WIDE_W-1:0] acc_r;
  logic [vcs_pkg::REM_W-1:0]  rem_r;
  logic [vcs_pkg::ROOT_W-1:0] root_r;
  logic [vcs_pkg::QUO_W-1:0]  q_r;
  logic [vcs_pkg::QUO_W-1:0]  nb_r;
  logic                       ovf_r;
  logic                       out_tvalid_r;
  logic [15:0]                out_tdata_r;
  logic                       out_tuser_r;

  logic [vcs_pkg::HALF_W-1:0] mul_x, mul_y;
  logic [vcs_pkg::PROD_W-1:0] mul_p;
  logic [1:0]                 sh_code;
  logic [vcs_pkg::WIDE_W-1:0] prod_sh;
  logic [vcs_pkg::REM_W-1:0]  sq_rem, sq_trial;
  logic [vcs_pkg::REM_W-1:0]  dv_rem, dv_root;
  logic                       ovf_now;
  logic [vcs_pkg::MAG_W-1:0]  head_mag;
  logic [vcs_pkg::QUO_W-1:0]  q_neg;
  logic [15:0]                sim;
  logic                       out_free;
  logic                       load_out;

  assign out_free = !out_tvalid_r || out_tready;

  // shared 22x22 multiplier for the four partial products of the norm product
  assign mul_x = cnt_r[1] ? {1'b0, sqa_r[42:22]} : sqa_r[21:0];
  assign mul_y = cnt_r[0] ? {1'b0, sqb_r[42:22]} : sqb_r[21:0];
  assign mul_p = mul_x * mul_y;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sh_code = 2'd0;
      2'd3:    sh_code = 2'd2;
      default: sh_code = 2'd1;
    endcase
  end

  always_comb begin
    case (sh_r)
      2'd0:    prod_sh = {{vcs_pkg::PROD_W{1'b0}}, prod_r};
      2'd1:    prod_sh = {{vcs_pkg::HALF_W{1'b0}}, prod_r, {vcs_pkg::HALF_W{1'b0}}};
      2'd2:    prod_sh = {prod_r, {vcs_pkg::PROD_W{1'b0}}};
      default: prod_sh = '0;
    endcase
  end

  // one root bit per cycle, two radicand bits shifted in from the top
  assign sq_rem   = {rem_r[43:0], acc_r[vcs_pkg::WIDE_W-1 -: 2]};
  assign sq_trial = {root_r, 2'b01};

  // one quotient bit per cycle
  assign dv_rem  = {rem_r[44:0], nb_r[vcs_pkg::QUO_W-1]};
  assign dv_root = {2'b00, root_r};
  // quotient of 2^17 or more saturates anyway
  assign ovf_now = ({4'b0, mag_r[43:2]} >= root_r);

  assign head_mag = head.dot[vcs_pkg::DOT_W-1] ? vcs_pkg::MAG_W'(-head.dot)
                                               : vcs_pkg::MAG_W'(head.dot);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vcs_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_nxt = (head.sq_a == '0 || head.sq_b == '0) ? vcs_pkg::ST_DONE
                                                          : vcs_pkg::ST_MUL;
        end
      end
      vcs_pkg::ST_MUL: begin
        if (cnt_r == vcs_pkg::MUL_STEPS) state_nxt = vcs_pkg::ST_SQRT;
      end
      vcs_pkg::ST_SQRT: begin
        if (cnt_r == vcs_pkg::SQRT_LAST) state_nxt = vcs_pkg::ST_DIV;
      end
      vcs_pkg::ST_DIV: begin
        if ((cnt_r == '0 && ovf_now) || cnt_r == vcs_pkg::DIV_STEPS) begin
          state_nxt = vcs_pkg::ST_DONE;
        end
      end
      vcs_pkg::ST_DONE: begin
        if (out_free) state_nxt = vcs_pkg::ST_IDLE;
      end
      default: state_nxt = vcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      vcs_pkg::ST_IDLE: pop      = head_valid;
      vcs_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vcs_pkg::ST_IDLE: begin
        if (head_valid) begin
          sqa_r  <= head.sq_a;
          sqb_r  <= head.sq_b;
          mag_r  <= head_mag;
          neg_r  <= head.dot[vcs_pkg::DOT_W-1];
          zero_r <= (head.sq_a == '0 || head.sq_b == '0);
          acc_r  <= '0;
          cnt_r  <= '0;
        end
      end
      vcs_pkg::ST_MUL: begin
        if (cnt_r != vcs_pkg::MUL_STEPS) begin
          prod_r <= mul_p;
          sh_r   <= sh_code;
        end
        if (cnt_r != '0) begin
          acc_r <= acc_r + prod_sh;
        end
        if (cnt_r == vcs_pkg::MUL_STEPS) begin
          cnt_r  <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + vcs_pkg::CNT_W'(1);
        end
      end
      vcs_pkg::ST_SQRT: begin
        acc_r <= {acc_r[vcs_pkg::WIDE_W-3:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_r  <= sq_rem - sq_trial;
          root_r <= {root_r[42:0], 1'b1};
        end else begin
          rem_r  <= sq_rem;
          root_r <= {root_r[42:0], 1'b0};
        end
        cnt_r <= (cnt_r == vcs_pkg::SQRT_LAST) ? '0 : cnt_r + vcs_pkg::CNT_W'(1);
      end
      vcs_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          ovf_r <= ovf_now;
          rem_r <= {4'b0, mag_r[43:2]};
          nb_r  <= {mag_r[1:0], 15'b0};
          q_r   <= '0;
        end else begin
          nb_r <= {nb_r[vcs_pkg::QUO_W-2:0], 1'b0};
          if (dv_rem >= dv_root) begin
            rem_r <= dv_rem - dv_root;
            q_r   <= {q_r[vcs_pkg::QUO_W-2:0], 1'b1};
          end else begin
            rem_r <= dv_rem;
            q_r   <= {q_r[vcs_pkg::QUO_W-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r + vcs_pkg::CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign q_neg = ~q_r + vcs_pkg::QUO_W'(1);

  always_comb begin
    if (zero_r) begin
      sim = '0;
    end else if (neg_r) begin
      sim = (ovf_r || q_r > vcs_pkg::NEG_LIMIT) ? vcs_pkg::SIM_MIN : q_neg[15:0];
    end else begin
      sim = (ovf_r || q_r > vcs_pkg::POS_LIMIT) ? vcs_pkg::SIM_MAX : q_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= sim;
      out_tuser_r <= zero_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/vector_cosine_similarity.sv -----
// streaming cosine similarity of two vectors, one element pair per item
// in channel: in_tdata carries a_elem (low half) and b_elem (high half),
// both signed Q1.15; in_tlast marks the final pair of the vectors.
// out channel: one item per vector, similarity in out_tdata (Q1.15,
// truncated toward zero and saturated), out_tuser is the zero norm flag.
// the front accumulates one pair per cycle while in_tready is high, through
// a registered product stage; on the last pair the sums go into a small
// queue (QUEUE_DEPTH). the back takes one vector at a time: the norm
// product on a shared 22x22 multiplier, a bit-serial square root, a
// bit-serial division that can end early when the quotient saturates, and
// a load of the output register; a zero norm goes straight to that load.
// sustained rate: one pair per cycle while vectors take at least as long to
// stream in as the back's per-vector time; shorter ones are limited by it.
// in_tready drops when the queue could overfill.
// a stalled receiver holds the result in the output register; the back then
// waits and the queue fills up before the input stalls.
// synchronous reset clears the sums, the queue and the output valid.
`include "vector_cosine_similarity_defines.svh"

module vector_cosine_similarity #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] a_elem, [31:16] b_elem
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] similarity
  output logic        out_tuser   // [0] zero_norm
);

  vcs_pkg::q_status_t q_status;
  vcs_pkg::acc_t      push_data;
  vcs_pkg::acc_t      head;
  logic               push;
  logic               pop;
  logic               head_valid;

  vcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  vcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .status     (q_status)
  );

  vcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `VCS_ASSERT_SAME(a_no_overflow, push, !q_status.full || pop, "queue overflow")
  `VCS_ASSERT_SAME(a_no_underflow, pop, head_valid, "pop from empty queue")
  `VCS_ASSERT_SAME(a_zero_result, out_tvalid && out_tuser, out_tdata == 16'h0000, "zero norm with nonzero result")
  `VCS_ASSERT_NEXT(a_reset_idle, !rst_n, !out_tvalid, "result valid after reset")

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_WAIT  = 100;

  localparam logic signed [vcs_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [vcs_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [vcs_pkg::DOT_W+1:0]  DOT_HI   =
    (46'sd1 <<< (vcs_pkg::DOT_W - 1)) - 46'sd1;
  localparam logic signed [vcs_pkg::DOT_W+1:0]  DOT_LO   =
    -(46'sd1 <<< (vcs_pkg::DOT_W - 1));
  localparam logic [vcs_pkg::SQ_W+1:0]          SQ_HI    = {2'b00, {vcs_pkg::SQ_W{1'b1}}};

  typedef struct packed {
    logic signed [vcs_pkg::SIM_W-1:0] similarity;
    logic                             zero_norm;
  } sim_result_t;

  class similarity_tracker;
    logic signed [vcs_pkg::DOT_W-1:0] dot_acc;
    logic [vcs_pkg::SQ_W-1:0]         sq_a_acc;
    logic [vcs_pkg::SQ_W-1:0]         sq_b_acc;
    sim_result_t                      expected_q[$];
    int                               mismatches;

    function new();
      dot_acc    = '0;
      sq_a_acc   = '0;
      sq_b_acc   = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // accumulate one element pair, closing the vector on the last one
    function void note_pair(logic signed [vcs_pkg::ELEM_W-1:0] a,
                            logic signed [vcs_pkg::ELEM_W-1:0] b, logic last);
      logic signed [31:0]                   prod_ab;
      logic signed [31:0]                   prod_aa;
      logic signed [31:0]                   prod_bb;
      logic signed [vcs_pkg::DOT_W+1:0]     dot_next;
      logic [vcs_pkg::SQ_W+1:0]             sq_a_next;
      logic [vcs_pkg::SQ_W+1:0]             sq_b_next;
      logic [2*vcs_pkg::SQ_W-1:0]           norm_prod;
      logic [vcs_pkg::ROOT_W-1:0]           root;
      logic [vcs_pkg::ROOT_W-1:0]           trial;
      logic [2*vcs_pkg::ROOT_W-1:0]         trial_sq;
      logic signed [vcs_pkg::DOT_W:0]       dot_wide;
      logic [vcs_pkg::DOT_W:0]              mag;
      logic [63:0]                          quot;
      logic                                 neg;
      sim_result_t                          res;

      prod_ab   = a * b;
      prod_aa   = a * a;
      prod_bb   = b * b;
      dot_next  = dot_acc + prod_ab;
      sq_a_next = sq_a_acc + $unsigned(prod_aa);
      sq_b_next = sq_b_acc + $unsigned(prod_bb);

      // sums clamp at the edges of their width rather than wrap
      if (dot_next > DOT_HI) begin
        dot_acc = DOT_HI[vcs_pkg::DOT_W-1:0];
      end else if (dot_next < DOT_LO) begin
        dot_acc = DOT_LO[vcs_pkg::DOT_W-1:0];
      end else begin
        dot_acc = dot_next[vcs_pkg::DOT_W-1:0];
      end
      sq_a_acc = (sq_a_next > SQ_HI) ? SQ_HI[vcs_pkg::SQ_W-1:0] : sq_a_next[vcs_pkg::SQ_W-1:0];
      sq_b_acc = (sq_b_next > SQ_HI) ? SQ_HI[vcs_pkg::SQ_W-1:0] : sq_b_next[vcs_pkg::SQ_W-1:0];

      if (!last) begin
        return;
      end

      if (sq_a_acc == '0 || sq_b_acc == '0) begin
        res.similarity = '0;
        res.zero_norm  = 1'b1;
      end else begin
        norm_prod = {{vcs_pkg::SQ_W{1'b0}}, sq_a_acc} * {{vcs_pkg::SQ_W{1'b0}}, sq_b_acc};
        // floor square root, one bit at a time from the top
        root = '0;
        for (int i = vcs_pkg::ROOT_W - 1; i >= 0; i--) begin
          trial    = root | (vcs_pkg::ROOT_W'(1) << i);
          trial_sq = {{vcs_pkg::ROOT_W{1'b0}}, trial} * {{vcs_pkg::ROOT_W{1'b0}}, trial};
          if (trial_sq <= norm_prod) begin
            root = trial;
          end
        end
        neg      = dot_acc < 0;
        dot_wide = dot_acc;
        mag      = neg ? -dot_wide : dot_wide;
        quot     = ({19'd0, mag} << 15) / root;
        if (neg) begin
          res.similarity = (quot > 64'd32768) ? vcs_pkg::SIM_MIN
                                              : vcs_pkg::SIM_W'(64'd0 - quot);
        end else begin
          res.similarity = (quot > 64'd32767) ? vcs_pkg::SIM_MAX
                                              : quot[vcs_pkg::SIM_W-1:0];
        end
        res.zero_norm = 1'b0;
      end
      expected_q.insert(expected_q.size(), res);

      dot_acc  = '0;
      sq_a_acc = '0;
      sq_b_acc = '0;
    endfunction

    function void check_result(logic signed [vcs_pkg::SIM_W-1:0] similarity, logic zero_norm);
      sim_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: similarity %0d zero_norm %0b",
                       similarity, zero_norm));
        return;
      end
      want = expected_q.pop_front();
      if (want.similarity !== similarity) begin
        flag($sformatf("similarity expected %0d got %0d", want.similarity, similarity));
      end
      if (want.zero_norm !== zero_norm) begin
        flag($sformatf("zero_norm expected %0b got %0b", want.zero_norm, zero_norm));
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] a_elem, [31:16] b_elem
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] similarity
  logic        out_tuser;         // [0] zero_norm

  int unsigned send_gap_pct  = 0;
  int unsigned ready_gap_pct = 0;
  int unsigned cycle_count   = 0;

  similarity_tracker tracker = new();

  vector_cosine_similarity i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL vector_cosine_similarity");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= ready_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tracker.note_pair(in_tdata[15:0], in_tdata[31:16], in_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata, out_tuser);
    end
  end

  task automatic send_pair(input logic signed [vcs_pkg::ELEM_W-1:0] a,
                           input logic signed [vcs_pkg::ELEM_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic signed [vcs_pkg::ELEM_W-1:0] pick_elem(int style);
    int unsigned pick;
    case (style)
      8: begin
        pick = $urandom_range(4);
        case (pick)
          0:       return ELEM_MIN;
          1:       return ELEM_MAX;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      9:       return vcs_pkg::ELEM_W'($urandom_range(16)) - 16'sd8;
      default: return vcs_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // random vectors of mostly short length; content style chosen per vector
  task automatic send_random_vectors(input int pair_count);
    int sent;
    int len;
    int style;
    int unsigned r;
    logic signed [vcs_pkg::ELEM_W-1:0] a;
    logic signed [vcs_pkg::ELEM_W-1:0] b;
    sent = 0;
    while (sent < pair_count) begin
      r     = $urandom_range(99);
      len   = (r < 70) ? $urandom_range(1, 12) :
              (r < 95) ? $urandom_range(13, 64) : $urandom_range(65, 150);
      style = $urandom_range(9);
      for (int k = 0; k < len; k++) begin
        a = (style == 7) ? 16'sd0 : pick_elem(style);
        case (style)
          4:       b = a;
          5:       b = -a;
          6:       b = a + vcs_pkg::ELEM_W'($urandom_range(6)) - 16'sd3;
          default: b = pick_elem(style);
        endcase
        send_pair(a, b, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct  = 19;
    ready_gap_pct = 46;

    // extreme one-pair vectors: equal ones overshoot q1.15, opposite give -1.0
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd1, ELEM_MIN, 1'b1);
    // zero norm on either side or both
    send_pair(16'sd0, 16'sd1234, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b0);
    send_pair(16'sd0, -16'sd7, 1'b1);
    send_pair(ELEM_MAX, 16'sd0, 1'b1);
    // orthogonal small vectors, then mixed vectors with larger elements
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, -16'sd1, 1'b0);
    send_pair(16'sd1, ELEM_MAX, 1'b1);
    send_pair(16'sd12345, -16'sd23456, 1'b0);
    send_pair(-16'sd321, 16'sd4000, 1'b1);

    send_random_vectors(190);

    send_gap_pct  = 46;
    ready_gap_pct = 19;
    send_random_vectors(190);

    send_gap_pct  = 0;
    ready_gap_pct = 0;
    send_random_vectors(140);
    in_tvalid <= 1'b0;

    while (tracker.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("PASS vector_cosine_similarity");
    end else begin
      $display("FAIL vector_cosine_similarity");
    end
    $finish;
  end

endmodule
